/* rtl/brf_pkg.sv */
// shared types, command codes and status codes for the byte ring fifo
package brf_pkg;

  localparam int unsigned DepthDefault  = 256;
  localparam int unsigned MaxRunDefault = 64;

  localparam logic [2:0] CmdPush     = 3'd0;
  localparam logic [2:0] CmdPop      = 3'd1;
  localparam logic [2:0] CmdClear    = 3'd2;
  localparam logic [2:0] CmdFirstLen = 3'd3;
  localparam logic [2:0] CmdLastLen  = 3'd4;
  localparam logic [2:0] CmdRun      = 3'd5;
  localparam logic [2:0] CmdRunDelim = 3'd6;
  localparam logic [2:0] CmdBad      = 3'd7;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StEmpty = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;
  localparam logic [1:0] StError = 2'd3;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] data_byte;
    logic [6:0] run_length;
  } cmd_t;

endpackage

/* rtl/brf_cmd_queue.sv */
// two entry command queue between the front and back parts
module brf_cmd_queue
  import brf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output cmd_t pop_data_o
);

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o     = cnt_q == 2'd2;
  assign valid_o    = cnt_q != 2'd0;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

/* rtl/brf_engine.sv */
// back part: ring storage, indices and the command sequencer
module brf_engine
  import brf_pkg::*;
#(
  parameter int unsigned DEPTH   = DepthDefault,
  parameter int unsigned MAX_RUN = MaxRunDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       overwrite_mode_i,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       cmd_take_o,
  output logic       idle_o,
  output logic       valid_o,
  output logic [1:0] status_o,
  output logic [7:0] data_out_o,
  output logic [7:0] count_o,
  output logic [7:0] fill_level_o,
  output logic       last_o
);

  localparam int unsigned AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int unsigned FW = AW + 1;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SPopRd = 3'd1;
  localparam logic [2:0] SScan  = 3'd2;
  localparam logic [2:0] SScanW = 3'd3;
  localparam logic [2:0] SRun   = 3'd4;
  localparam logic [2:0] SRunW  = 3'd5;

  logic [7:0]    store_q [DEPTH];
  logic [7:0]    rdata_q;
  logic [AW-1:0] rd_q, wr_q, scan_q;
  logic [FW-1:0] pos_q, found_q, left_q;
  logic [2:0]    state_q;
  cmd_t          cur_q;
  logic          out_v_q, out_last_q;
  logic [1:0]    out_st_q;
  logic [7:0]    out_d_q, out_c_q, out_f_q;

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] i);
    inc = (FW'(i) == FW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [7:0] sat(input logic [FW-1:0] v);
    sat = (32'(v) > 32'd255) ? 8'hff : 8'(v);
  endfunction

  logic [FW-1:0] fill;
  logic [AW-1:0] raddr;
  logic          full;
  assign fill = (wr_q >= rd_q) ? FW'(wr_q) - FW'(rd_q) : FW'(wr_q) + FW'(DEPTH) - FW'(rd_q);
  assign full = inc(wr_q) == rd_q;
  assign raddr = (state_q == SIdle) ? rd_q : scan_q;

  assign cmd_take_o   = state_q == SIdle && cmd_valid_i;
  assign idle_o       = state_q == SIdle && !cmd_valid_i && !out_v_q;
  assign valid_o      = out_v_q;
  assign status_o     = out_st_q;
  assign data_out_o   = out_d_q;
  assign count_o      = out_c_q;
  assign fill_level_o = out_f_q;
  assign last_o       = out_last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_take_o && cmd_i.cmd == CmdPush && !(full && !overwrite_mode_i)) begin
      store_q[wr_q] <= cmd_i.data_byte;
    end
    rdata_q <= store_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      rd_q       <= '0;
      wr_q       <= '0;
      scan_q     <= '0;
      pos_q      <= '0;
      found_q    <= '0;
      left_q     <= '0;
      cur_q      <= '0;
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
      out_st_q   <= StOk;
      out_d_q    <= '0;
      out_c_q    <= '0;
      out_f_q    <= '0;
    end else begin
      out_v_q <= 1'b0;
      case (state_q)
        SIdle: begin
          if (cmd_valid_i) begin
            cur_q      <= cmd_i;
            out_st_q   <= StOk;
            out_d_q    <= '0;
            out_c_q    <= '0;
            out_f_q    <= sat(fill);
            out_last_q <= 1'b1;
            scan_q     <= rd_q;
            pos_q      <= '0;
            found_q    <= '0;
            case (cmd_i.cmd)
              CmdPush: begin
                out_v_q <= 1'b1;
                if (full && !overwrite_mode_i) begin
                  out_st_q <= StFull;
                end else begin
                  wr_q <= inc(wr_q);
                  if (full) begin
                    rd_q     <= inc(inc(wr_q));
                    out_st_q <= StFull;
                  end else begin
                    out_f_q <= sat(fill + 1'b1);
                  end
                end
              end
              CmdPop: begin
                if (rd_q == wr_q) begin
                  out_v_q  <= 1'b1;
                  out_st_q <= StEmpty;
                  out_f_q  <= '0;
                end else begin
                  rd_q    <= inc(rd_q);
                  out_f_q <= sat(fill - 1'b1);
                  state_q <= SPopRd;
                end
              end
              CmdClear: begin
                out_v_q <= 1'b1;
                rd_q    <= '0;
                wr_q    <= '0;
                out_f_q <= '0;
              end
              CmdFirstLen, CmdLastLen, CmdRunDelim: begin
                if (fill == '0) begin
                  if (cmd_i.cmd == CmdRunDelim && cmd_i.run_length != '0) begin
                    out_st_q <= StError;
                  end
                  out_v_q <= 1'b1;
                end else begin
                  state_q <= SScanW;
                end
              end
              CmdRun: begin
                if (32'(cmd_i.run_length) > MAX_RUN
                    || 32'(cmd_i.run_length) > 32'(fill)) begin
                  out_v_q  <= 1'b1;
                  out_st_q <= StError;
                end else if (cmd_i.run_length == '0) begin
                  out_v_q <= 1'b1;
                end else begin
                  left_q  <= FW'(cmd_i.run_length);
                  out_f_q <= sat(fill - FW'(cmd_i.run_length));
                  state_q <= SRunW;
                end
              end
              default: begin
                out_v_q  <= 1'b1;
                out_st_q <= StError;
              end
            endcase
          end
        end
        SPopRd: begin
          out_v_q <= 1'b1;
          out_d_q <= rdata_q;
          state_q <= SIdle;
        end
        SScanW: begin
          scan_q  <= inc(scan_q);
          state_q <= SScan;
        end
        SScan: begin
          logic [FW-1:0] f;
          logic          done;
          f    = found_q;
          done = 1'b0;
          if (rdata_q == cur_q.data_byte) begin
            f = pos_q + 1'b1;
            if (cur_q.cmd == CmdFirstLen) done = 1'b1;
          end
          if (pos_q + 1'b1 == fill) done = 1'b1;
          found_q <= f;
          pos_q   <= pos_q + 1'b1;
          scan_q  <= inc(scan_q);
          if (done) begin
            if (cur_q.cmd == CmdRunDelim) begin
              if (32'(cur_q.run_length) > MAX_RUN || 32'(cur_q.run_length) > 32'(f)) begin
                out_v_q  <= 1'b1;
                out_st_q <= StError;
                state_q  <= SIdle;
              end else if (cur_q.run_length == '0) begin
                out_v_q <= 1'b1;
                state_q <= SIdle;
              end else begin
                left_q  <= FW'(cur_q.run_length);
                scan_q  <= rd_q;
                out_f_q <= sat(fill - FW'(cur_q.run_length));
                state_q <= SRunW;
              end
            end else begin
              out_v_q <= 1'b1;
              out_c_q <= sat(f);
              state_q <= SIdle;
            end
          end else begin
            state_q <= SScan;
          end
        end
        SRunW: begin
          scan_q  <= inc(scan_q);
          state_q <= SRun;
        end
        SRun: begin
          out_v_q    <= 1'b1;
          out_d_q    <= rdata_q;
          out_last_q <= left_q == FW'(1);
          rd_q       <= inc(rd_q);
          scan_q     <= inc(scan_q);
          left_q     <= left_q - 1'b1;
          if (left_q == FW'(1)) state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

endmodule

/* rtl/byte_ring_fifo_with_delimiter_search_top.sv */
// top level of the byte ring fifo with delimiter search
//  channel  | handshake            | payload
//  command  | start / busy         | cmd_i, data_byte_i, run_length_i
//  result   | result_valid_o       | status_o, data_out_o, count_o, fill_level_o, last_o
//  config   | overwrite_we_i       | overwrite_wdata_i
// push, clear, empty pop, rejected and error commands: the queue, then the engine's idle state
// registers the result; pop: also the store read; delimiter queries: a store scan at one entry
// per cycle (none when empty); a first delimiter query ends at the match
// run pops: store read (after the scan for run to delimiter), then one byte per cycle
// reset clears indices, queue and mode (overwrite on); store content is undefined
// commands queue up to two deep; the receiver cannot stall results
module byte_ring_fifo_with_delimiter_search_top
  import brf_pkg::*;
#(
  parameter int unsigned DEPTH   = DepthDefault,
  parameter int unsigned MAX_RUN = MaxRunDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] cmd_i,
  input  logic [7:0] data_byte_i,
  input  logic [6:0] run_length_i,
  input  logic       overwrite_we_i,
  input  logic       overwrite_wdata_i,
  output logic       result_valid_o,
  output logic [1:0] status_o,
  output logic [7:0] data_out_o,
  output logic [7:0] count_o,
  output logic [7:0] fill_level_o,
  output logic       last_o
);

  logic mode_q;
  logic q_full, q_valid, take, idle;
  cmd_t q_in, q_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
    end else if (overwrite_we_i) begin
      mode_q <= overwrite_wdata_i;
    end
  end

  assign busy = q_full;
  assign q_in = '{cmd: cmd_i, data_byte: data_byte_i, run_length: run_length_i};

  brf_cmd_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(start && !q_full), .push_data_i(q_in), .full_o(q_full),
    .valid_o(q_valid), .pop_i(take), .pop_data_o(q_out)
  );

  brf_engine #(.DEPTH(DEPTH), .MAX_RUN(MAX_RUN)) u_engine (
    .clk_i, .rst_ni,
    .overwrite_mode_i(mode_q),
    .cmd_valid_i(q_valid), .cmd_i(q_out), .cmd_take_o(take), .idle_o(idle),
    .valid_o(result_valid_o), .status_o, .data_out_o, .count_o, .fill_level_o, .last_o
  );

`ifndef ASSERT_OFF
  a_take_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> q_valid) else $error("take from empty queue");
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle |-> !result_valid_o) else $error("result while idle");
  a_last_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o != StOk) |-> last_o) else $error("error not last");
`endif

endmodule
